// ----- hw/rtl/fsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the format specifier scanner.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int MAX_STRING_LEN = 65536;
    localparam int POS_W          = $clog2(MAX_STRING_LEN + 1);
    localparam int LEN_W          = (POS_W + 1 > 17) ? POS_W + 1 : 17;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_N       = 8'h6E;
    localparam logic [7:0] CHR_DOT     = 8'h2E;
    localparam logic [7:0] CHR_HASH    = 8'h23;
    localparam logic [7:0] CHR_Q       = 8'h71;
    localparam logic [7:0] CHR_C       = 8'h63;
    localparam logic [7:0] CHR_S       = 8'h73;

    typedef enum logic [2:0] {
        ARG_NONE    = 3'd0,
        ARG_INTEGER = 3'd1,
        ARG_FLOAT   = 3'd2,
        ARG_STRING  = 3'd3,
        ARG_CHAR    = 3'd4
    } t_arg_class;

    // One queue entry: an optional specifier record and an optional summary.
    typedef struct packed {
        logic        has_spec;
        logic [15:0] spec_start;
        logic [15:0] spec_length;
        t_arg_class  arg_class;
        logic        has_final;
        logic [15:0] arg_total;
        logic        rejected;
        logic        too_long;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hw/rtl/fsc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_front
// Accepts one character per cycle while the queue is not full, runs the scan
// state machine and pushes the resulting records into the queue.
// ----------------------------------------------------------------------------
module fsc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_string,
    input  fsc_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output fsc_pkg::t_entry     o_entry
);

    typedef enum logic [2:0] {
        MODE_LITERAL,
        MODE_PERCENT,
        MODE_FLAGS,
        MODE_WIDTH,
        MODE_PRECISION,
        MODE_LENGTH
    } t_mode;

    t_mode                     r_mode, n_mode;
    logic [fsc_pkg::POS_W-1:0] r_position, n_position;
    logic [fsc_pkg::POS_W-1:0] r_open_start, n_open_start;
    logic [15:0]               r_arg_count, n_arg_count;
    logic                      r_reject, n_reject;
    logic                      r_overflow, n_overflow;

    logic                      accept;
    logic                      spec_hit;
    fsc_pkg::t_arg_class       spec_cls;
    logic [fsc_pkg::LEN_W-1:0] span;
    logic                      early;
    logic                      mid;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_flag(input logic [7:0] c);
        return (c == "-") || (c == "+") || (c == " ") || (c == "0") ||
               (c == fsc_pkg::CHR_HASH);
    endfunction

    function automatic logic is_length_mod(input logic [7:0] c);
        return (c == "h") || (c == "l") || (c == "L") || (c == "z") ||
               (c == "j") || (c == "t") || (c == fsc_pkg::CHR_Q);
    endfunction

    function automatic fsc_pkg::t_arg_class class_of(input logic [7:0] c);
        fsc_pkg::t_arg_class cls;
        case (c)
            "d", "i", "u", "x", "X", "o": cls = fsc_pkg::ARG_INTEGER;
            "f", "F", "e", "E", "g", "G", "a", "A": cls = fsc_pkg::ARG_FLOAT;
            fsc_pkg::CHR_C: cls = fsc_pkg::ARG_CHAR;
            fsc_pkg::CHR_S: cls = fsc_pkg::ARG_STRING;
            default: cls = fsc_pkg::ARG_STRING;
        endcase
        return cls;
    endfunction

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    // Length of the open specifier; it is saturated to 16 bits in the entry.
    assign span = fsc_pkg::LEN_W'(r_position) - fsc_pkg::LEN_W'(r_open_start)
                + fsc_pkg::LEN_W'(1);

    // Modes from which flags, width digits or a dot may still follow.
    assign early = (r_mode == MODE_PERCENT) || (r_mode == MODE_FLAGS);
    assign mid   = early || (r_mode == MODE_WIDTH);

    always_comb begin
        n_mode       = r_mode;
        n_position   = r_position;
        n_open_start = r_open_start;
        n_arg_count  = r_arg_count;
        n_reject     = r_reject;
        n_overflow   = r_overflow;
        spec_hit     = 1'b0;
        spec_cls     = fsc_pkg::ARG_NONE;
        o_entry      = '0;

        if (accept) begin
            if (r_position >= fsc_pkg::POS_W'(fsc_pkg::MAX_STRING_LEN)) begin
                n_overflow = 1'b1;
            end else begin
                n_position = r_position + fsc_pkg::POS_W'(1);
                if (!r_reject) begin
                    case (r_mode)
                        MODE_LITERAL: begin
                            if (i_char_code == fsc_pkg::CHR_PERCENT) begin
                                n_open_start = r_position;
                                n_mode       = MODE_PERCENT;
                            end
                        end
                        default: begin
                            if (r_mode == MODE_PERCENT &&
                                i_char_code == fsc_pkg::CHR_PERCENT) begin
                                spec_hit = 1'b1;
                                spec_cls = fsc_pkg::ARG_NONE;
                                n_mode   = MODE_LITERAL;
                            end else if (early && is_flag(i_char_code)) begin
                                n_mode = MODE_FLAGS;
                            end else if (mid && is_digit(i_char_code)) begin
                                n_mode = MODE_WIDTH;
                            end else if (mid && i_char_code == fsc_pkg::CHR_DOT) begin
                                n_mode = MODE_PRECISION;
                            end else if (r_mode == MODE_PRECISION &&
                                         is_digit(i_char_code)) begin
                                n_mode = MODE_PRECISION;
                            end else if (is_length_mod(i_char_code)) begin
                                n_mode = MODE_LENGTH;
                            end else begin
                                n_mode = MODE_LITERAL;
                                if (i_char_code == fsc_pkg::CHR_N) begin
                                    n_reject = 1'b1;
                                end else begin
                                    spec_hit = 1'b1;
                                    spec_cls = class_of(i_char_code);
                                    if (r_arg_count != 16'hFFFF) begin
                                        n_arg_count = r_arg_count + 16'd1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end

            o_entry.has_spec    = spec_hit;
            o_entry.spec_start  = 16'(r_open_start);
            o_entry.spec_length = (span > fsc_pkg::LEN_W'(16'hFFFF)) ? 16'hFFFF
                                                                     : 16'(span);
            o_entry.arg_class   = spec_cls;
            o_entry.has_final   = i_end_of_string;
            o_entry.arg_total   = n_reject ? 16'd0 : n_arg_count;
            o_entry.rejected    = n_reject;
            o_entry.too_long    = n_overflow;

            // The summary closes the string; the next item starts a new one.
            if (i_end_of_string) begin
                n_mode       = MODE_LITERAL;
                n_position   = '0;
                n_open_start = '0;
                n_arg_count  = '0;
                n_reject     = 1'b0;
                n_overflow   = 1'b0;
            end
        end
    end

    assign o_push = accept && (spec_hit || i_end_of_string);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_LITERAL;
            r_position   <= '0;
            r_open_start <= '0;
            r_arg_count  <= '0;
            r_reject     <= 1'b0;
            r_overflow   <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_position   <= n_position;
            r_open_start <= n_open_start;
            r_arg_count  <= n_arg_count;
            r_reject     <= n_reject;
            r_overflow   <= n_overflow;
        end
    end

endmodule

// ----- hw/rtl/fsc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_queue
// Short register queue of record entries between the front and back parts.
// ----------------------------------------------------------------------------
module fsc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fsc_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output fsc_pkg::t_entry    o_head,
    output fsc_pkg::t_q_status o_status
);

    fsc_pkg::t_entry          r_mem [fsc_pkg::Q_DEPTH];
    logic [fsc_pkg::Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [fsc_pkg::Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [fsc_pkg::Q_CW-1:0] r_count, n_count;

    assign o_status.full  = (r_count == fsc_pkg::Q_CW'(fsc_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == fsc_pkg::Q_AW'(fsc_pkg::Q_DEPTH - 1)) ? '0
                     : r_wr_ptr + fsc_pkg::Q_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == fsc_pkg::Q_AW'(fsc_pkg::Q_DEPTH - 1)) ? '0
                     : r_rd_ptr + fsc_pkg::Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + fsc_pkg::Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - fsc_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hw/rtl/fsc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_back
// Unpacks queue entries into result items and holds them in an output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
module fsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsc_pkg::t_entry    i_head,
    input  fsc_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_spec_start,
    output logic [15:0]        o_spec_length,
    output logic [2:0]         o_arg_class,
    output logic               o_final_record,
    output logic [15:0]        o_arg_total,
    output logic               o_rejected,
    output logic               o_too_long
);

    logic                r_out_valid, n_out_valid;
    logic                r_spec_done, n_spec_done;
    logic                load;
    logic                take_spec;
    logic [15:0]         r_spec_start;
    logic [15:0]         r_spec_length;
    fsc_pkg::t_arg_class r_arg_class;
    logic                r_final_record;
    logic [15:0]         r_arg_total;
    logic                r_rejected;
    logic                r_too_long;

    // The output register can take a new item when it is empty or being read.
    assign load      = (!r_out_valid || !i_stall) && !i_q_status.empty;
    assign take_spec = i_head.has_spec && !r_spec_done;
    // An entry with both records stays at the head until its summary goes out.
    assign o_pop     = load && !(take_spec && i_head.has_final);

    always_comb begin
        n_out_valid = r_out_valid;
        n_spec_done = r_spec_done;
        if (!r_out_valid || !i_stall) begin
            n_out_valid = !i_q_status.empty;
        end
        if (load) begin
            n_spec_done = take_spec && i_head.has_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_spec_done <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_spec_done <= n_spec_done;
        end
        if (load) begin
            if (take_spec) begin
                r_spec_start   <= i_head.spec_start;
                r_spec_length  <= i_head.spec_length;
                r_arg_class    <= i_head.arg_class;
                r_final_record <= 1'b0;
                r_arg_total    <= '0;
                r_rejected     <= 1'b0;
                r_too_long     <= 1'b0;
            end else begin
                r_spec_start   <= '0;
                r_spec_length  <= '0;
                r_arg_class    <= fsc_pkg::ARG_NONE;
                r_final_record <= 1'b1;
                r_arg_total    <= i_head.arg_total;
                r_rejected     <= i_head.rejected;
                r_too_long     <= i_head.too_long;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_spec_start   = r_spec_start;
    assign o_spec_length  = r_spec_length;
    assign o_arg_class    = r_arg_class;
    assign o_final_record = r_final_record;
    assign o_arg_total    = r_arg_total;
    assign o_rejected     = r_rejected;
    assign o_too_long     = r_too_long;

endmodule

// ----- hw/rtl/format_specifier_scanner.sv -----
`timescale 1ns / 1ps
// A record reaches the output through the queue and the output register.
// Throughput: one character per cycle while the queue is not full; the
// four-entry queue absorbs the extra record of a character that yields a specifier
// and a summary. The output register drains one record per cycle unless stalled.
// Reset (synchronous): scanner returns to literal text, counters clear, queue
// and output register empty.
// ----------------------------------------------------------------------------
// format_specifier_scanner
// Scans a printf-style format string one character per item and reports
// each conversion specifier plus an end-of-string summary.
// ----------------------------------------------------------------------------
module format_specifier_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_spec_start,
    output logic [15:0] o_spec_length,
    output logic [2:0]  o_arg_class,
    output logic        o_final_record,
    output logic [15:0] o_arg_total,
    output logic        o_rejected,
    output logic        o_too_long
);

    logic               q_push;
    logic               q_pop;
    fsc_pkg::t_entry    q_in;
    fsc_pkg::t_entry    q_head;
    fsc_pkg::t_q_status q_status;

    fsc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_code     (i_char_code),
        .i_end_of_string (i_end_of_string),
        .i_q_status      (q_status),
        .o_push          (q_push),
        .o_entry         (q_in)
    );

    fsc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    fsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_q_status     (q_status),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_spec_start   (o_spec_start),
        .o_spec_length  (o_spec_length),
        .o_arg_class    (o_arg_class),
        .o_final_record (o_final_record),
        .o_arg_total    (o_arg_total),
        .o_rejected     (o_rejected),
        .o_too_long     (o_too_long)
    );

    // The queue is never written while it is full.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    // Nothing is popped from an empty queue.
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // A rejected string reports no arguments, and only in its summary.
    a_reject_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_final_record && o_arg_total == 16'd0))
        else $error("rejected flag outside a clean summary record");

    // A specifier record always covers at least the percent sign.
    a_spec_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_record) |-> (o_spec_length != 16'd0 && !o_too_long))
        else $error("specifier record with empty length");

endmodule

// ----- sim/format_specifier_scanner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_specifier_scanner_tb
// Streams printf-style format strings into the scanner, one byte per item,
// with random gaps on the input and random stalls on the output. A scanner
// model inside the bench predicts every specifier and summary record, and
// each record taken from the block is checked field by field in order.
// ----------------------------------------------------------------------------
module format_specifier_scanner_tb;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 600;

    localparam string FLAG_SET   = "-+ 0#";
    localparam string DIGIT_SET  = "0123456789";
    localparam string LENGTH_SET = "hlLzjtq";
    localparam string CONV_SET   = "diuxXofFeEgGaAcspS%";

    typedef enum logic [2:0] {
        SCAN_LITERAL,
        SCAN_PERCENT,
        SCAN_FLAGS,
        SCAN_WIDTH,
        SCAN_PRECISION,
        SCAN_LENGTH
    } t_scan_mode;

    typedef struct packed {
        logic [15:0]         start;
        logic [15:0]         length;
        fsc_pkg::t_arg_class cls;
        logic                fin;
        logic [15:0]         total;
        logic                rej;
        logic                too_long;
    } t_scan_record;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_char_code     = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_spec_start;
    logic [15:0] o_spec_length;
    logic [2:0]  o_arg_class;
    logic        o_final_record;
    logic [15:0] o_arg_total;
    logic        o_rejected;
    logic        o_too_long;

    // Scanner model state.
    t_scan_mode  sc_mode;
    int unsigned sc_pos;
    int unsigned sc_open;
    int unsigned sc_args;
    logic        sc_reject;
    logic        sc_overflow;

    t_scan_record records_due[$];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    int           tx_gap_max     = 10;
    int           rx_gap_max     = 10;
    int           rx_wait        = 0;
    int           quiet_cycles   = 0;

    format_specifier_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_code     (i_char_code),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_spec_start    (o_spec_start),
        .o_spec_length   (o_spec_length),
        .o_arg_class     (o_arg_class),
        .o_final_record  (o_final_record),
        .o_arg_total     (o_arg_total),
        .o_rejected      (o_rejected),
        .o_too_long      (o_too_long)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic void clear_scan_state();
        sc_mode     = SCAN_LITERAL;
        sc_pos      = 0;
        sc_open     = 0;
        sc_args     = 0;
        sc_reject   = 1'b0;
        sc_overflow = 1'b0;
    endfunction

    function automatic void expect_record(input t_scan_record rec);
        records_due = {records_due, rec};
    endfunction

    function automatic t_scan_record spec_record(input fsc_pkg::t_arg_class cls);
        t_scan_record rec;
        int unsigned  len;
        rec        = '0;
        len        = sc_pos - sc_open + 1;
        rec.start  = sc_open[15:0];
        rec.length = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
        rec.cls    = cls;
        return rec;
    endfunction

    // Modes fall through in order, so a byte that ends one field is tried
    // against the next one within the same step.
    function automatic bit parse_char(input logic [7:0] c, output t_scan_record rec);
        t_scan_mode          m;
        fsc_pkg::t_arg_class cls;
        rec = '0;
        m   = sc_mode;
        if (m == SCAN_LITERAL) begin
            if (c == fsc_pkg::CHR_PERCENT) begin
                sc_open = sc_pos;
                sc_mode = SCAN_PERCENT;
            end
            return 1'b0;
        end
        if (m == SCAN_PERCENT) begin
            if (c == fsc_pkg::CHR_PERCENT) begin
                rec     = spec_record(fsc_pkg::ARG_NONE);
                sc_mode = SCAN_LITERAL;
                return 1'b1;
            end
            m = SCAN_FLAGS;
        end
        if (m == SCAN_FLAGS) begin
            if (c == "-" || c == "+" || c == " " || c == "0" ||
                c == fsc_pkg::CHR_HASH) begin
                sc_mode = SCAN_FLAGS;
                return 1'b0;
            end
            m = SCAN_WIDTH;
        end
        if (m == SCAN_WIDTH) begin
            if (c >= "0" && c <= "9") begin
                sc_mode = SCAN_WIDTH;
                return 1'b0;
            end
            if (c == fsc_pkg::CHR_DOT) begin
                sc_mode = SCAN_PRECISION;
                return 1'b0;
            end
            m = SCAN_LENGTH;
        end
        if (m == SCAN_PRECISION) begin
            if (c >= "0" && c <= "9") begin
                sc_mode = SCAN_PRECISION;
                return 1'b0;
            end
        end
        if (c == "h" || c == "l" || c == "L" || c == "z" || c == "j" || c == "t" ||
            c == fsc_pkg::CHR_Q) begin
            sc_mode = SCAN_LENGTH;
            return 1'b0;
        end
        sc_mode = SCAN_LITERAL;
        if (c == fsc_pkg::CHR_N) begin
            sc_reject = 1'b1;
            return 1'b0;
        end
        case (c)
            "d", "i", "u", "x", "X", "o":           cls = fsc_pkg::ARG_INTEGER;
            "f", "F", "e", "E", "g", "G", "a", "A": cls = fsc_pkg::ARG_FLOAT;
            fsc_pkg::CHR_C:                         cls = fsc_pkg::ARG_CHAR;
            default:                                cls = fsc_pkg::ARG_STRING;
        endcase
        rec = spec_record(cls);
        if (sc_args < 32'hFFFF) sc_args++;
        return 1'b1;
    endfunction

    function automatic void scan_char(input logic [7:0] c, input logic eos);
        t_scan_record rec;
        if (sc_pos >= fsc_pkg::MAX_STRING_LEN) begin
            sc_overflow = 1'b1;
        end else begin
            if (!sc_reject) begin
                if (parse_char(c, rec)) expect_record(rec);
            end
            sc_pos++;
        end
        if (eos) begin
            rec          = '0;
            rec.fin      = 1'b1;
            rec.total    = sc_reject ? 16'h0000 : sc_args[15:0];
            rec.rej      = sc_reject;
            rec.too_long = sc_overflow;
            expect_record(rec);
            clear_scan_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic eos);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_char_code     <= c;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scan_char(c, eos);
        items_sent++;
    endtask

    task automatic send_format(ref logic [7:0] fmt[$]);
        foreach (fmt[i]) send_char(fmt[i], i == fmt.size() - 1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (records_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Format string generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic add_byte(ref logic [7:0] fmt[$], input logic [7:0] c);
        fmt = {fmt, c};
    endtask

    task automatic append_text(ref logic [7:0] fmt[$], input string s);
        for (int i = 0; i < s.len(); i++) add_byte(fmt, s[i]);
    endtask

    task automatic append_literal(ref logic [7:0] fmt[$]);
        logic [7:0] c;
        int         n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            do begin
                c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(32, 126));
            end while (c == fsc_pkg::CHR_PERCENT);
            add_byte(fmt, c);
        end
    endtask

    // An incomplete specifier stops before its conversion byte.
    task automatic append_spec(ref logic [7:0] fmt[$], input bit complete);
        int n;
        int pick;
        add_byte(fmt, fsc_pkg::CHR_PERCENT);
        if (complete && $urandom_range(0, 7) == 0) begin
            add_byte(fmt, fsc_pkg::CHR_PERCENT);
            return;
        end
        n = $urandom_range(0, 3);
        repeat (n) add_byte(fmt, pick_from(FLAG_SET));
        n = $urandom_range(0, 2);
        repeat (n) add_byte(fmt, pick_from(DIGIT_SET));
        if ($urandom_range(0, 2) == 0) begin
            add_byte(fmt, fsc_pkg::CHR_DOT);
            n = $urandom_range(0, 2);
            repeat (n) add_byte(fmt, pick_from(DIGIT_SET));
        end
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) add_byte(fmt, pick_from(LENGTH_SET));
        if (!complete) return;
        pick = $urandom_range(0, 49);
        if (pick == 0)
            add_byte(fmt, fsc_pkg::CHR_N);
        else if (pick == 1)
            add_byte(fmt, 8'($urandom_range(0, 255)));
        else
            add_byte(fmt, pick_from(CONV_SET));
    endtask

    task automatic build_random_format(ref logic [7:0] fmt[$]);
        int kind;
        int n;
        fmt.delete();
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            // Noise: arbitrary bytes with percent signs sprinkled in.
            n = $urandom_range(1, 12);
            repeat (n) begin
                add_byte(fmt, ($urandom_range(0, 3) == 0) ? fsc_pkg::CHR_PERCENT
                                                          : 8'($urandom_range(0, 255)));
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 2) == 0)
                    append_literal(fmt);
                else
                    append_spec(fmt, 1'b1);
            end
            if (kind == 2) append_spec(fmt, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stalls at random and checks every record in order.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 50)
            $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : record_check
        t_scan_record want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (records_due.size() == 0) begin
                    report_mismatch("record with none pending", {16'h0, o_spec_start},
                                    32'd0);
                end else begin
                    want = records_due.pop_front();
                    if (o_spec_start !== want.start)
                        report_mismatch("spec_start", 32'(o_spec_start), 32'(want.start));
                    if (o_spec_length !== want.length)
                        report_mismatch("spec_length", 32'(o_spec_length),
                                        32'(want.length));
                    if (o_arg_class !== want.cls)
                        report_mismatch("arg_class", 32'(o_arg_class), 32'(want.cls));
                    if (o_final_record !== want.fin)
                        report_mismatch("final_record", 32'(o_final_record),
                                        32'(want.fin));
                    if (o_arg_total !== want.total)
                        report_mismatch("arg_total", 32'(o_arg_total), 32'(want.total));
                    if (o_rejected !== want.rej)
                        report_mismatch("rejected", 32'(o_rejected), 32'(want.rej));
                    if (o_too_long !== want.too_long)
                        report_mismatch("too_long", 32'(o_too_long), 32'(want.too_long));
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (rx_wait > 0) begin
                i_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL format_specifier_scanner");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] fmt[$];
        // A lone percent is a specifier cut off by the end of the string.
        fmt.delete();
        append_text(fmt, "%");
        send_format(fmt);
        // Top byte value as text, a doubled percent, then a character
        // conversion on the last byte so both records come from one item.
        fmt.delete();
        add_byte(fmt, 8'hFF);
        append_text(fmt, "%%%c");
        send_format(fmt);
        // Flag, precision and length modifiers ahead of float and integer.
        fmt.delete();
        append_text(fmt, "%+.7tg%ld");
        send_format(fmt);
        // A percent after a flag is a conversion of its own; then %n
        // rejects the string and the trailing zero byte is ignored.
        fmt.delete();
        append_text(fmt, "%0%%n");
        add_byte(fmt, 8'h00);
        send_format(fmt);
        fmt.delete();
        append_text(fmt, "%5");
        send_format(fmt);
    endtask

    task automatic test_random_strings();
        logic [7:0] fmt[$];
        int         first_item;
        int         strings_done;
        first_item   = items_sent;
        strings_done = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end else begin
                tx_gap_max = 10;
                rx_gap_max = 10;
            end
            build_random_format(fmt);
            send_format(fmt);
            strings_done++;
            if (strings_done % 40 == 0) wait_drained();
        end
        tx_gap_max = 10;
        rx_gap_max = 10;
    endtask

    // Back-to-back strings, then the sender holds off until every record is in.
    task automatic test_sender_pause();
        logic [7:0] fmt[$];
        tx_gap_max = 0;
        repeat (3) begin
            repeat (3) begin
                build_random_format(fmt);
                send_format(fmt);
            end
            wait_drained();
        end
        tx_gap_max = 10;
    endtask

    initial begin
        clear_scan_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_strings();
        test_sender_pause();
        test_random_strings();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && records_due.size() == 0) begin
            $display("PASS format_specifier_scanner");
        end else begin
            $display("FAIL format_specifier_scanner");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_front.sv
hw/rtl/fsc_queue.sv
hw/rtl/fsc_back.sv
hw/rtl/format_specifier_scanner.sv
sim/format_specifier_scanner_tb.sv
